FILE: hdl/keymap_layer_resolver_core_defines.svh
// assertion macros for the layer resolver checker
`ifndef KEYMAP_LAYER_RESOLVER_CORE_DEFINES_SVH
`define KEYMAP_LAYER_RESOLVER_CORE_DEFINES_SVH

// same-cycle implication
`define KLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/klr_pkg.sv
`timescale 1ns / 1ps
package klr_pkg;

    localparam int LAYERS = 16;
    localparam int KEYS   = 64;
    localparam int RULES  = 4;

    localparam int LAYER_W  = $clog2(LAYERS);
    localparam int DEPTH    = LAYERS * KEYS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int RULE_REGS = 4;
    localparam int RULE_IDX_W = 2;

    localparam logic [15:0] ALL_LAYERS = 16'((33'd1 << LAYERS) - 33'd1);
    localparam logic [15:0] HALF_TRANS = 16'hFFFF;
    localparam logic [3:0]  DANCE_KIND = 4'hE;
    localparam int          KIND_SHIFT = 28;
    localparam int          HALF_SHIFT = 16;

    // item kinds
    localparam logic [3:0] KIND_LOAD     = 4'd0;
    localparam logic [3:0] KIND_SET      = 4'd1;
    localparam logic [3:0] KIND_ON       = 4'd2;
    localparam logic [3:0] KIND_OFF      = 4'd3;
    localparam logic [3:0] KIND_TOGGLE   = 4'd4;
    localparam logic [3:0] KIND_P_SET    = 4'd5;
    localparam logic [3:0] KIND_P_ON     = 4'd6;
    localparam logic [3:0] KIND_P_OFF    = 4'd7;
    localparam logic [3:0] KIND_DEFAULT  = 4'd8;
    localparam logic [3:0] KIND_RESOLVE  = 4'd9;

    // register indexes
    localparam logic [2:0] REG_TRANSP     = 3'd0;
    localparam logic [2:0] REG_RULE_COUNT = 3'd1;
    localparam logic [2:0] REG_RULE_ZERO  = 3'd2;
    localparam logic [2:0] REG_RULE_ONE   = 3'd3;
    localparam logic [2:0] REG_RULE_TWO   = 3'd4;
    localparam logic [2:0] REG_RULE_THREE = 3'd5;

    typedef struct packed {
        logic [3:0]  kind;
        logic [5:0]  key_index;
        logic [3:0]  layer_number;
        logic [15:0] layer_mask;
        logic [31:0] entry_code;
    } klr_item_t;

    typedef struct packed {
        logic [31:0] resolved_code;
        logic [15:0] momentary_mask;
        logic [15:0] persistent_mask;
        logic [3:0]  highest_layer;
        logic [3:0]  default_layer;
    } klr_result_t;

    // keymap address of one layer and key
    function automatic logic [ADDR_W-1:0] klr_addr(input logic [LAYER_W-1:0] layer,
                                                   input logic [5:0] key);
        return ADDR_W'(int'(layer) * KEYS + int'(key));
    endfunction

    // open halves become zero
    function automatic logic [31:0] klr_close(input logic [15:0] hold,
                                              input logic [15:0] tap);
        logic [15:0] h;
        logic [15:0] t;
        h = (hold == HALF_TRANS) ? 16'd0 : hold;
        t = (tap == HALF_TRANS) ? 16'd0 : tap;
        return {h, t};
    endfunction

endpackage

FILE: hdl/klr_ram.sv
`timescale 1ns / 1ps
module klr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/klr_rule_unit.sv
`timescale 1ns / 1ps
module klr_rule_unit (
    input  logic [15:0] momentary,
    input  logic [15:0] persistent,
    input  logic [19:0] rule,
    output logic [15:0] momentary_out
);
    import klr_pkg::*;

    logic [15:0] need;
    logic [3:0]  target;
    logic [15:0] active;
    logic [15:0] bit_sel;

    assign need    = rule[15:0];
    assign target  = rule[19:16];
    assign active  = (momentary | persistent) & ALL_LAYERS;
    assign bit_sel = 16'd1 << target;

    // force target on when all required layers are active, else off
    always_comb
    begin
        momentary_out = momentary;
        if (5'(target) < 5'(LAYERS))
        begin
            if ((active & need) == need)
            begin
                momentary_out = (momentary | bit_sel) & ALL_LAYERS;
            end
            else
            begin
                momentary_out = momentary & ~bit_sel & ALL_LAYERS;
            end
        end
    end

endmodule

FILE: hdl/keymap_layer_resolver_core.sv
`timescale 1ns / 1ps
// Keymap layer resolver. An item is taken when start is high and busy is low;
// busy stays high while the item is worked on. Each item gives exactly one
// result word, shown on result for the single cycle in which done is high;
// the receiver takes it then and cannot hold it off. A new item may be
// started in the cycle done is high.
// Work per item after it is taken:
//   load entry, unused kinds, ignored layers: straight to the result word
//   mask changes: then the rules in order (one rule per cycle through
//     the shared rule unit)
//   resolve without transparency: one keymap read
//   resolve with transparency: one keymap read per active layer visited,
//     inactive layers skipped; the single keymap read port serves them all
// The keymap sits in one RAM, written by load items, read one layer at a time.
// Configuration must be written through cfg_write/cfg_index/cfg_data while
// idle; the block does not enforce this. Reset clears the momentary mask,
// sets persistent layer 0, enables transparency and zeroes the rules; keymap
// contents are undefined until loaded and no clearing pass is made.
module keymap_layer_resolver_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  klr_pkg::klr_item_t   item,
    output logic                 busy,
    output logic                 done,
    output klr_pkg::klr_result_t result,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [19:0]          cfg_data
);
    import klr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RULE,
        ST_READ,
        ST_EVAL,
        ST_FLAT,
        ST_FIN
    } state_t;

    state_t      state_reg, state_next;
    klr_item_t   item_reg, item_next;
    logic [15:0] mom_reg, mom_next;
    logic [15:0] pers_reg, pers_next;
    logic [2:0]  rcnt_reg, rcnt_next;
    logic [LAYER_W-1:0] lyr_reg, lyr_next;
    logic [15:0] hold_reg, hold_next;
    logic [15:0] tap_reg, tap_next;
    logic [31:0] code_reg, code_next;
    logic        done_reg, done_next;
    klr_result_t result_reg, result_next;

    logic        transp_reg;
    logic [2:0]  rule_count_reg;
    logic [19:0] rule_reg [RULE_REGS];

    logic [15:0] active;
    logic [15:0] layer_bit;
    logic        layer_ok;
    logic        key_ok;
    logic [2:0]  rule_limit;
    logic [15:0] rule_mom;
    logic [LAYER_W-1:0] top_layer;
    logic [LAYER_W-1:0] base_layer;
    logic        ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0] ram_rdata;
    logic [15:0] ev_hold;
    logic [15:0] ev_tap;
    logic        ev_ht;
    logic        ev_tt;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transp_reg     <= 1'b1;
            rule_count_reg <= 3'd0;
            for (int i = 0; i < RULE_REGS; i++)
            begin
                rule_reg[i] <= 20'd0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRANSP:     transp_reg     <= cfg_data[0];
                REG_RULE_COUNT: rule_count_reg <= cfg_data[2:0];
                REG_RULE_ZERO:  rule_reg[0]    <= cfg_data;
                REG_RULE_ONE:   rule_reg[1]    <= cfg_data;
                REG_RULE_TWO:   rule_reg[2]    <= cfg_data;
                REG_RULE_THREE: rule_reg[3]    <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign active     = (mom_reg | pers_reg) & ALL_LAYERS;
    assign layer_ok   = 5'(item_reg.layer_number) < 5'(LAYERS);
    assign key_ok     = 9'(item_reg.key_index) < 9'(KEYS);
    assign layer_bit  = layer_ok ? (16'd1 << item_reg.layer_number) : 16'd0;
    assign rule_limit = (rule_count_reg > 3'(RULES)) ? 3'(RULES) : rule_count_reg;

    // highest active layer above 0 and lowest persistent layer
    always_comb
    begin
        top_layer  = '0;
        base_layer = '0;
        for (int l = 1; l < LAYERS; l++)
        begin
            if (active[l])
            begin
                top_layer = LAYER_W'(l);
            end
        end
        for (int l = LAYERS - 1; l >= 0; l--)
        begin
            if (pers_reg[l])
            begin
                base_layer = LAYER_W'(l);
            end
        end
    end

    // shared rule unit, one rule per cycle
    klr_rule_unit u_rule (
        .momentary     (mom_reg),
        .persistent    (pers_reg),
        .rule          (rule_reg[rcnt_reg[RULE_IDX_W-1:0]]),
        .momentary_out (rule_mom)
    );

    // keymap memory
    assign ram_we    = (state_reg == ST_EXEC) && (item_reg.kind == KIND_LOAD)
                       && layer_ok && key_ok;
    assign ram_waddr = klr_addr(item_reg.layer_number[LAYER_W-1:0], item_reg.key_index);
    assign ram_raddr = (state_reg == ST_READ) ? klr_addr(lyr_reg, item_reg.key_index)
                                              : klr_addr(top_layer, item_reg.key_index);

    klr_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_keymap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.entry_code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // halves after taking the word just read
    assign ev_ht   = hold_reg == HALF_TRANS;
    assign ev_tt   = tap_reg == HALF_TRANS;
    assign ev_hold = ev_ht ? ram_rdata[31:HALF_SHIFT] : hold_reg;
    assign ev_tap  = ev_tt ? ram_rdata[HALF_SHIFT-1:0] : tap_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        mom_next    = mom_reg;
        pers_next   = pers_reg;
        rcnt_next   = rcnt_reg;
        lyr_next    = lyr_reg;
        hold_next   = hold_reg;
        tap_next    = tap_reg;
        code_next   = code_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    code_next  = 32'd0;
                    rcnt_next  = 3'd0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
                unique case (item_reg.kind)
                    KIND_SET:
                    begin
                        mom_next   = item_reg.layer_mask & ALL_LAYERS;
                        state_next = ST_RULE;
                    end
                    KIND_ON, KIND_OFF, KIND_TOGGLE:
                    begin
                        if (layer_ok)
                        begin
                            if (item_reg.kind == KIND_ON ||
                                (item_reg.kind == KIND_TOGGLE &&
                                 (active & layer_bit) == 16'd0))
                            begin
                                mom_next = (mom_reg | layer_bit) & ALL_LAYERS;
                            end
                            else
                            begin
                                mom_next = mom_reg & ~layer_bit & ALL_LAYERS;
                            end
                            state_next = ST_RULE;
                        end
                    end
                    KIND_P_SET:
                    begin
                        pers_next  = item_reg.layer_mask & ALL_LAYERS;
                        state_next = ST_RULE;
                    end
                    KIND_P_ON, KIND_P_OFF, KIND_DEFAULT:
                    begin
                        if (layer_ok)
                        begin
                            if (item_reg.kind == KIND_P_ON)
                            begin
                                pers_next = (pers_reg | layer_bit) & ALL_LAYERS;
                            end
                            else if (item_reg.kind == KIND_P_OFF)
                            begin
                                pers_next = pers_reg & ~layer_bit & ALL_LAYERS;
                            end
                            else
                            begin
                                pers_next = layer_bit & ALL_LAYERS;
                            end
                            state_next = ST_RULE;
                        end
                    end
                    KIND_RESOLVE:
                    begin
                        if (key_ok)
                        begin
                            if (transp_reg)
                            begin
                                lyr_next   = LAYER_W'(LAYERS - 1);
                                hold_next  = HALF_TRANS;
                                tap_next   = HALF_TRANS;
                                state_next = ST_READ;
                            end
                            else
                            begin
                                state_next = ST_FLAT;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_RULE:
            begin
                if (rcnt_reg >= rule_limit)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    mom_next  = rule_mom;
                    rcnt_next = rcnt_reg + 3'd1;
                end
            end
            ST_READ:
            begin
                // read data is used only for an active layer
                if (active[lyr_reg])
                begin
                    state_next = ST_EVAL;
                end
                else if (lyr_reg == '0)
                begin
                    code_next  = klr_close(hold_reg, tap_reg);
                    state_next = ST_FIN;
                end
                else
                begin
                    lyr_next = lyr_reg - LAYER_W'(1);
                end
            end
            ST_EVAL:
            begin
                hold_next = ev_hold;
                tap_next  = ev_tap;
                if (ram_rdata[31:KIND_SHIFT] == DANCE_KIND && (ev_ht != ev_tt))
                begin
                    // tap dance met with one half open
                    code_next  = 32'd0;
                    state_next = ST_FIN;
                end
                else if ((ev_hold != HALF_TRANS && ev_tap != HALF_TRANS) ||
                         lyr_reg == '0)
                begin
                    code_next  = klr_close(ev_hold, ev_tap);
                    state_next = ST_FIN;
                end
                else
                begin
                    lyr_next   = lyr_reg - LAYER_W'(1);
                    state_next = ST_READ;
                end
            end
            ST_FLAT:
            begin
                code_next  = ram_rdata;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                result_next.resolved_code   = code_reg;
                result_next.momentary_mask  = mom_reg;
                result_next.persistent_mask = pers_reg;
                result_next.highest_layer   = 4'(top_layer);
                result_next.default_layer   = 4'(base_layer);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mom_reg   <= 16'd0;
            pers_reg  <= 16'd1;
            done_reg  <= 1'b0;
            rcnt_reg  <= 3'd0;
            lyr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mom_reg   <= mom_next;
            pers_reg  <= pers_next;
            done_reg  <= done_next;
            rcnt_reg  <= rcnt_next;
            lyr_reg   <= lyr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        hold_reg   <= hold_next;
        tap_reg    <= tap_next;
        code_reg   <= code_next;
        result_reg <= result_next;
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: hdl/klr_checker.sv
`timescale 1ns / 1ps
`include "keymap_layer_resolver_core_defines.svh"
module klr_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input klr_pkg::klr_item_t   item,
    input logic                 busy,
    input logic                 done,
    input klr_pkg::klr_result_t result,
    input logic                 cfg_write,
    input logic [2:0]           cfg_index,
    input logic [19:0]          cfg_data
);
    import klr_pkg::*;

    logic [15:0] unused_mask;

    // ports not checked here
    assign unused_mask = item.layer_mask ^ result.momentary_mask ^ cfg_data[15:0]
                         ^ {13'd0, cfg_index} ^ {15'd0, cfg_write};

    // an accepted word makes the block busy
    `KLR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")
    // a result word is only shown while idle
    `KLR_ASSERT_NOW(a_done_idle, clk, rst_n, done, !busy, "done while busy")
    // the strobe lasts one cycle
    `KLR_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done longer than one cycle")
    // finishing an item always delivers its word
    `KLR_ASSERT_NOW(a_fall_done, clk, rst_n, $fell(busy), done, "item ended without word")

endmodule

bind keymap_layer_resolver_core klr_checker u_klr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

FILE: bench/keymap_layer_resolver_core_test.sv
`timescale 1ns / 1ps
module keymap_layer_resolver_core_test;
    import klr_pkg::*;

    // item kinds with no function in the block
    localparam logic [3:0] KIND_SPARE_FIRST = 4'd10;
    localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        start;
    klr_item_t   item;
    logic        busy;
    logic        done;
    klr_result_t result;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [19:0] cfg_data;

    // shadow of the block state and registers
    logic [15:0] mom_layers;
    logic [15:0] per_layers;
    logic [31:0] keymap_words [LAYERS*KEYS];
    bit          entry_loaded [LAYERS*KEYS];
    bit          transp_on;
    logic [2:0]  rules_used;
    logic [19:0] rule_word [4];

    klr_result_t expected_words [$];
    klr_result_t want_word;
    int          mismatches;
    int          sender_idle_pct;
    int          words_sent;

    keymap_layer_resolver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("keymap_layer_resolver_core_test NOT OK");
        $finish;
    end

    // layer state after reset
    function automatic void reset_shadow();
        int i;
        mom_layers = '0;
        per_layers = 16'd1;
        transp_on  = 1'b1;
        rules_used = '0;
        for (i = 0; i < 4; i++)
            rule_word[i] = '0;
        for (i = 0; i < LAYERS*KEYS; i++)
            entry_loaded[i] = 1'b0;
    endfunction

    // rules in order: force target on when all required layers are active, else off
    function automatic void run_rules();
        int          n;
        int          i;
        logic [15:0] need;
        logic [3:0]  tgt;
        n = (int'(rules_used) < RULES) ? int'(rules_used) : RULES;
        for (i = 0; i < n; i++)
        begin
            need = rule_word[i][15:0];
            tgt  = rule_word[i][19:16];
            if (int'(tgt) < LAYERS)
                mom_layers[tgt] = (((mom_layers | per_layers) & ALL_LAYERS & need) == need);
        end
    endfunction

    function automatic logic [3:0] top_active();
        logic [15:0] act;
        int          l;
        act = (mom_layers | per_layers) & ALL_LAYERS;
        for (l = LAYERS - 1; l > 0; l--)
            if (act[l])
                return 4'(l);
        return 4'd0;
    endfunction

    function automatic logic [3:0] lowest_persistent();
        int l;
        for (l = 0; l < LAYERS; l++)
            if (per_layers[l])
                return 4'(l);
        return 4'd0;
    endfunction

    // key code seen through the active layers, transparent halves falling through
    function automatic logic [31:0] lookup_code(input logic [5:0] key);
        logic [15:0] act;
        logic [15:0] hold;
        logic [15:0] tap;
        logic [31:0] code;
        bit          ht;
        bit          tt;
        int          l;
        act = (mom_layers | per_layers) & ALL_LAYERS;
        if (!transp_on)
            return keymap_words[int'(top_active()) * KEYS + int'(key)];
        hold = HALF_TRANS;
        tap  = HALF_TRANS;
        for (l = LAYERS - 1; l >= 0; l--)
        begin
            if (act[l])
            begin
                code = keymap_words[l * KEYS + int'(key)];
                ht = (hold == HALF_TRANS);
                tt = (tap == HALF_TRANS);
                // tap dance code with one half already settled
                if (code[31:28] == DANCE_KIND && ht != tt)
                    return 32'd0;
                if (ht)
                    hold = code[31:16];
                if (tt)
                    tap = code[15:0];
                if (hold != HALF_TRANS && tap != HALF_TRANS)
                    break;
            end
        end
        if (hold == HALF_TRANS)
            hold = '0;
        if (tap == HALF_TRANS)
            tap = '0;
        return {hold, tap};
    endfunction

    // update the shadow with one accepted word and return its result word
    function automatic klr_result_t apply_word(input klr_item_t w);
        klr_result_t r;
        logic [15:0] act;
        int          addr;
        r    = '0;
        act  = (mom_layers | per_layers) & ALL_LAYERS;
        addr = int'(w.layer_number) * KEYS + int'(w.key_index);
        case (w.kind)
            KIND_LOAD:
            begin
                keymap_words[addr] = w.entry_code;
                entry_loaded[addr] = 1'b1;
            end
            KIND_SET:
            begin
                mom_layers = w.layer_mask & ALL_LAYERS;
                run_rules();
            end
            KIND_ON, KIND_OFF, KIND_TOGGLE:
            begin
                mom_layers[w.layer_number] = (w.kind == KIND_ON) ||
                    (w.kind == KIND_TOGGLE && !act[w.layer_number]);
                run_rules();
            end
            KIND_P_SET:
            begin
                per_layers = w.layer_mask & ALL_LAYERS;
                run_rules();
            end
            KIND_P_ON, KIND_P_OFF:
            begin
                per_layers[w.layer_number] = (w.kind == KIND_P_ON);
                run_rules();
            end
            KIND_DEFAULT:
            begin
                per_layers = 16'd1 << w.layer_number;
                run_rules();
            end
            KIND_RESOLVE:
                r.resolved_code = lookup_code(w.key_index);
            default:
                r.resolved_code = '0;
        endcase
        r.momentary_mask  = mom_layers;
        r.persistent_mask = per_layers;
        r.highest_layer   = top_active();
        r.default_layer   = lowest_persistent();
        return r;
    endfunction

    function automatic klr_item_t make_word(input logic [3:0] kind, input logic [5:0] key,
                                            input logic [3:0] layer, input logic [15:0] mask,
                                            input logic [31:0] code);
        klr_item_t w;
        w.kind         = kind;
        w.key_index    = key;
        w.layer_number = layer;
        w.layer_mask   = mask;
        w.entry_code   = code;
        return w;
    endfunction

    // codes biased toward transparent halves and tap dance codes
    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 32'($urandom);
            1: return {HALF_TRANS, 16'($urandom)};
            2: return {16'($urandom), HALF_TRANS};
            3: return {HALF_TRANS, HALF_TRANS};
            4: return {DANCE_KIND, 28'($urandom)};
            default: return {DANCE_KIND, 12'($urandom), HALF_TRANS};
        endcase
    endfunction

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(0, 4))
            0: return 16'($urandom) & 16'($urandom) & 16'($urandom);
            1: return 16'($urandom);
            2: return 16'd1 << $urandom_range(0, LAYERS - 1);
            3: return 16'd0;
            default: return ALL_LAYERS;
        endcase
    endfunction

    // random word, mostly layer changes and resolves on a few keys
    function automatic klr_item_t pick_word();
        klr_item_t w;
        int        roll;
        w = make_word(4'($urandom), 6'($urandom), 4'($urandom), 16'($urandom), 32'($urandom));
        if ($urandom_range(0, 3) != 0)
            w.key_index = 6'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            w.kind       = KIND_LOAD;
            w.entry_code = pick_code();
        end
        else if (roll < 20)
        begin
            w.kind       = KIND_SET;
            w.layer_mask = pick_mask();
        end
        else if (roll < 32)
            w.kind = KIND_ON;
        else if (roll < 42)
            w.kind = KIND_OFF;
        else if (roll < 52)
            w.kind = KIND_TOGGLE;
        else if (roll < 57)
        begin
            w.kind       = KIND_P_SET;
            w.layer_mask = pick_mask();
        end
        else if (roll < 64)
            w.kind = KIND_P_ON;
        else if (roll < 70)
            w.kind = KIND_P_OFF;
        else if (roll < 74)
            w.kind = KIND_DEFAULT;
        else if (roll < 96)
            w.kind = KIND_RESOLVE;
        else
            w.kind = 4'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        return w;
    endfunction

    // send one word; start stays high so the next word can follow at once
    task automatic send_word(input klr_item_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_words.push_back(apply_word(w));
        words_sent++;
    endtask

    // load every keymap entry the resolve could read before sending it
    task automatic resolve_safely(input klr_item_t w);
        logic [15:0] need_layers;
        klr_item_t   fill;
        int          l;
        need_layers = mom_layers | per_layers | 16'd1;
        for (l = 0; l < LAYERS; l++)
        begin
            if (need_layers[l] && !entry_loaded[l * KEYS + int'(w.key_index)])
            begin
                fill = make_word(KIND_LOAD, w.key_index, 4'(l), 16'($urandom), pick_code());
                send_word(fill);
            end
        end
        send_word(w);
    endtask

    task automatic resolve_key(input logic [5:0] key);
        resolve_safely(make_word(KIND_RESOLVE, key, 4'd0, 16'd0, 32'd0));
    endtask

    // wait until every expected word has come back and the block has settled
    task automatic drain_words();
        start <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_TRANSP:     transp_on = data[0];
            REG_RULE_COUNT: rules_used = data[2:0];
            REG_RULE_ZERO:  rule_word[0] = data;
            REG_RULE_ONE:   rule_word[1] = data;
            REG_RULE_TWO:   rule_word[2] = data;
            REG_RULE_THREE: rule_word[3] = data;
            default:        ;
        endcase
    endtask

    task automatic configure(input bit transp, input logic [2:0] count,
                             input logic [19:0] r0, input logic [19:0] r1,
                             input logic [19:0] r2, input logic [19:0] r3);
        drain_words();
        write_reg(REG_TRANSP, 20'(transp));
        write_reg(REG_RULE_COUNT, 20'(count));
        write_reg(REG_RULE_ZERO, r0);
        write_reg(REG_RULE_ONE, r1);
        write_reg(REG_RULE_TWO, r2);
        write_reg(REG_RULE_THREE, r3);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [19:0] pick_rule();
        case ($urandom_range(0, 4))
            0: return {4'($urandom), 16'd0};
            1: return 20'hFFFFF;
            2: return {4'($urandom), 16'd1 << $urandom_range(0, LAYERS - 1)};
            3: return {4'($urandom), 16'($urandom) & 16'($urandom) & 16'($urandom)};
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic configure_random();
        configure(1'($urandom), 3'($urandom_range(0, 7)),
                  pick_rule(), pick_rule(), pick_rule(), pick_rule());
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $time);
    endtask

    // masks after reset, seen through a word the block ignores
    task automatic test_reset_values();
        send_word(make_word(KIND_SPARE_LAST, 6'h3F, 4'hF, 16'hFFFF, 32'hFFFFFFFF));
    endtask

    // transparent halves, tap dance codes and the no-transparency path
    task automatic test_resolve_paths();
        send_word(make_word(KIND_LOAD, 6'd0, 4'd0, 16'd0, 32'h00410042));
        send_word(make_word(KIND_LOAD, 6'd0, 4'd1, 16'd0, 32'hFFFF0011));
        send_word(make_word(KIND_LOAD, 6'd0, 4'd2, 16'd0, 32'h0022FFFF));
        send_word(make_word(KIND_LOAD, 6'd0, 4'd3, 16'd0, 32'hE1234567));
        send_word(make_word(KIND_LOAD, 6'd0, 4'd5, 16'd0, 32'h0055FFFF));
        send_word(make_word(KIND_LOAD, 6'd63, 4'd15, 16'd0, 32'hFFFFFFFF));
        send_word(make_word(KIND_LOAD, 6'd63, 4'd0, 16'd0, 32'hFFFFFFFF));
        // hold half falls through to the base layer
        send_word(make_word(KIND_ON, 6'd0, 4'd1, 16'd0, 32'd0));
        resolve_key(6'd0);
        // tap half falls through one layer
        send_word(make_word(KIND_ON, 6'd0, 4'd2, 16'd0, 32'd0));
        resolve_key(6'd0);
        // tap dance code with both halves open
        send_word(make_word(KIND_ON, 6'd0, 4'd3, 16'd0, 32'd0));
        resolve_key(6'd0);
        // tap dance code under an open tap half gives zero
        send_word(make_word(KIND_SET, 6'd0, 4'd0, 16'h0000, 32'd0));
        send_word(make_word(KIND_P_SET, 6'd0, 4'd0, 16'h0028, 32'd0));
        resolve_key(6'd0);
        // halves still open below the lowest layer give zero
        send_word(make_word(KIND_P_SET, 6'd0, 4'd0, 16'h0001, 32'd0));
        send_word(make_word(KIND_SET, 6'd0, 4'd0, 16'h8000, 32'd0));
        resolve_key(6'd63);
        // no transparency, nothing active above the base layer
        configure(1'b0, 3'd0, 20'h0, 20'h0, 20'h0, 20'h0);
        send_word(make_word(KIND_SET, 6'd0, 4'd0, 16'h0000, 32'd0));
        resolve_key(6'd0);
    endtask

    // rule chains, a rule that always holds, and more rules than the block uses
    task automatic test_layer_rules();
        configure(1'b1, 3'd7, {4'd7, 16'h0000}, 20'hFFFFF, {4'd9, 16'h0002},
                  {4'd12, 16'h0200});
        send_word(make_word(KIND_ON, 6'd0, 4'd1, 16'd0, 32'd0));
        send_word(make_word(KIND_TOGGLE, 6'd0, 4'd1, 16'd0, 32'd0));
        send_word(make_word(KIND_P_ON, 6'd0, 4'd15, 16'd0, 32'd0));
        send_word(make_word(KIND_P_OFF, 6'd0, 4'd15, 16'd0, 32'd0));
        send_word(make_word(KIND_DEFAULT, 6'd0, 4'd3, 16'd0, 32'd0));
        send_word(make_word(KIND_SPARE_FIRST, 6'd0, 4'd0, 16'd0, 32'd0));
    endtask

    // count covers every word sent, keymap fills included
    task automatic test_random_traffic(input int idle_pct, input int count);
        klr_item_t w;
        int        n;
        int        stop_at;
        sender_idle_pct = idle_pct;
        stop_at         = words_sent + count;
        n               = 0;
        while (words_sent < stop_at)
        begin
            if (n % 105 == 0)
                configure_random();
            w = pick_word();
            if (w.kind == KIND_RESOLVE)
                resolve_safely(w);
            else
                send_word(w);
            n++;
        end
    endtask

    // compare each result word against the oldest expected word
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                note_mismatch("unexpected word", 32'd0, result.resolved_code);
            else
            begin
                want_word = expected_words.pop_front();
                if (result.resolved_code !== want_word.resolved_code)
                    note_mismatch("resolved_code", want_word.resolved_code,
                                  result.resolved_code);
                if (result.momentary_mask !== want_word.momentary_mask)
                    note_mismatch("momentary_mask", 32'(want_word.momentary_mask),
                                  32'(result.momentary_mask));
                if (result.persistent_mask !== want_word.persistent_mask)
                    note_mismatch("persistent_mask", 32'(want_word.persistent_mask),
                                  32'(result.persistent_mask));
                if (result.highest_layer !== want_word.highest_layer)
                    note_mismatch("highest_layer", 32'(want_word.highest_layer),
                                  32'(result.highest_layer));
                if (result.default_layer !== want_word.default_layer)
                    note_mismatch("default_layer", 32'(want_word.default_layer),
                                  32'(result.default_layer));
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        cfg_write       = 1'b0;
        cfg_index       = REG_TRANSP;
        cfg_data        = '0;
        mismatches      = 0;
        words_sent      = 0;
        sender_idle_pct = 26;
        reset_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_resolve_paths();
        test_layer_rules();
        test_random_traffic(26, 405);
        test_random_traffic(63, 405);
        test_random_traffic(0, 405);

        // let any stray word show up after the last expected one
        drain_words();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("keymap_layer_resolver_core_test OK");
        else
            $display("keymap_layer_resolver_core_test NOT OK");
        $finish;
    end

endmodule
